// ===== rtl/bmcs_pkg.sv =====
`timescale 1ns / 1ps

package bmcs_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 2;
  localparam int SCORE_W = 63;
  localparam int SUM_W   = SCORE_W + 3;
  localparam int OUT_W   = 80;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Bracket characters.
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_LANGLE = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_RANGLE = 8'h3E;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CORRUPT  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } line_status_e;

  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic char_en;
    logic pop_en;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stack_empty;
    logic line_bad;
  } dp_status_t;

endpackage

// ===== rtl/bmcs_ctrl.sv =====
`timescale 1ns / 1ps

module bmcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_eol_i,
  input  logic                out_ready_i,
  input  bmcs_pkg::dp_status_t status_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output bmcs_pkg::dp_cmd_t   cmd_o
);

  bmcs_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_fire;
  logic out_free;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmcs_pkg::ST_IDLE: begin
        if (in_fire && in_eol_i) begin
          state_d = bmcs_pkg::ST_DRAIN;
        end
      end
      bmcs_pkg::ST_DRAIN: begin
        if ((status_i.line_bad || status_i.stack_empty) && out_free) begin
          state_d = bmcs_pkg::ST_IDLE;
        end
      end
      default: state_d = bmcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      bmcs_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.char_en = in_valid_i;
      end
      bmcs_pkg::ST_DRAIN: begin
        if (!status_i.line_bad && !status_i.stack_empty) begin
          cmd_o.pop_en = 1'b1;
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // The result slot fills on a load and empties when the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmcs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/bmcs_dp.sv =====
`timescale 1ns / 1ps

module bmcs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bmcs_pkg::CHAR_W-1:0]   char_i,
  input  bmcs_pkg::dp_cmd_t             cmd_i,
  output bmcs_pkg::dp_status_t          status_o,
  output logic [1:0]                    line_status_o,
  output logic [bmcs_pkg::CHAR_W-1:0]   offending_char_o,
  output logic [bmcs_pkg::SCORE_W-1:0]  completion_score_o,
  output logic                          score_saturated_o
);

  logic [bmcs_pkg::KIND_W-1:0] stack_mem [bmcs_pkg::STACK_DEPTH];

  logic [bmcs_pkg::CNT_W-1:0]   count_q, count_d;
  logic                         corrupt_q, corrupt_d;
  logic                         exceeded_q, exceeded_d;
  logic [bmcs_pkg::CHAR_W-1:0]  bad_q, bad_d;
  logic [bmcs_pkg::SCORE_W-1:0] score_q, score_d;
  logic                         sat_q, sat_d;

  logic [1:0]                   ostat_q, ostat_d;
  logic [bmcs_pkg::CHAR_W-1:0]  obad_q, obad_d;
  logic [bmcs_pkg::SCORE_W-1:0] oscore_q, oscore_d;
  logic                         osat_q, osat_d;

  logic                         is_open, is_close;
  logic [bmcs_pkg::KIND_W-1:0]  kind;
  logic [bmcs_pkg::PTR_W-1:0]   rd_idx, wr_idx;
  logic [bmcs_pkg::KIND_W-1:0]  top_q;
  logic [bmcs_pkg::KIND_W-1:0]  top_kind;
  logic                         full, empty, push;
  logic [bmcs_pkg::SUM_W-1:0]   sum;
  logic                         sum_ovf;

  always_comb begin
    is_open  = 1'b0;
    is_close = 1'b0;
    kind     = '0;
    unique case (char_i)
      bmcs_pkg::CH_LPAREN: begin is_open  = 1'b1; kind = 2'd0; end
      bmcs_pkg::CH_LBRACK: begin is_open  = 1'b1; kind = 2'd1; end
      bmcs_pkg::CH_LBRACE: begin is_open  = 1'b1; kind = 2'd2; end
      bmcs_pkg::CH_LANGLE: begin is_open  = 1'b1; kind = 2'd3; end
      bmcs_pkg::CH_RPAREN: begin is_close = 1'b1; kind = 2'd0; end
      bmcs_pkg::CH_RBRACK: begin is_close = 1'b1; kind = 2'd1; end
      bmcs_pkg::CH_RBRACE: begin is_close = 1'b1; kind = 2'd2; end
      bmcs_pkg::CH_RANGLE: begin is_close = 1'b1; kind = 2'd3; end
      default: ;
    endcase
  end

  assign empty    = (count_q == '0);
  assign full     = (count_q == bmcs_pkg::CNT_W'(bmcs_pkg::STACK_DEPTH));
  assign rd_idx   = bmcs_pkg::PTR_W'(count_d - 1'b1);
  assign wr_idx   = bmcs_pkg::PTR_W'(count_q);
  assign top_kind = top_q;
  assign push     = cmd_i.char_en && !corrupt_q && !exceeded_q && is_open && !full;

  // score * 5 + (kind + 1); anything above bit 62 means the score overflowed.
  assign sum = {3'b000, score_q} + {1'b0, score_q, 2'b00}
             + bmcs_pkg::SUM_W'({1'b0, top_kind} + 3'd1);
  assign sum_ovf = sat_q || (sum[bmcs_pkg::SUM_W-1:bmcs_pkg::SCORE_W] != '0);

  always_comb begin
    count_d    = count_q;
    corrupt_d  = corrupt_q;
    exceeded_d = exceeded_q;
    bad_d      = bad_q;
    score_d    = score_q;
    sat_d      = sat_q;
    ostat_d    = ostat_q;
    obad_d     = obad_q;
    oscore_d   = oscore_q;
    osat_d     = osat_q;

    if (cmd_i.char_en && !corrupt_q && !exceeded_q) begin
      if (is_open) begin
        if (full) begin
          exceeded_d = 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end else if (is_close && !empty) begin
        if (top_kind == kind) begin
          count_d = count_q - 1'b1;
        end else begin
          corrupt_d = 1'b1;
          bad_d     = char_i;
        end
      end
    end

    if (cmd_i.pop_en) begin
      count_d = count_q - 1'b1;
      if (sum_ovf) begin
        score_d = bmcs_pkg::SCORE_MAX;
        sat_d   = 1'b1;
      end else begin
        score_d = sum[bmcs_pkg::SCORE_W-1:0];
      end
    end

    if (cmd_i.load_out) begin
      if (corrupt_q) begin
        ostat_d = bmcs_pkg::STATUS_CORRUPT;
      end else if (exceeded_q) begin
        ostat_d = bmcs_pkg::STATUS_OVERFLOW;
      end else begin
        ostat_d = bmcs_pkg::STATUS_OK;
      end
      obad_d     = corrupt_q ? bad_q : '0;
      oscore_d   = (corrupt_q || exceeded_q) ? '0 : score_q;
      osat_d     = sat_q && !corrupt_q && !exceeded_q;
      count_d    = '0;
      corrupt_d  = 1'b0;
      exceeded_d = 1'b0;
      bad_d      = '0;
      score_d    = '0;
      sat_d      = 1'b0;
    end
  end

  // The top entry is held in a register. A push forwards the new kind;
  // otherwise the entry just below the next count is read.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[wr_idx] <= kind;
      top_q             <= kind;
    end else begin
      top_q <= stack_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      corrupt_q  <= 1'b0;
      exceeded_q <= 1'b0;
      bad_q      <= '0;
      score_q    <= '0;
      sat_q      <= 1'b0;
    end else begin
      count_q    <= count_d;
      corrupt_q  <= corrupt_d;
      exceeded_q <= exceeded_d;
      bad_q      <= bad_d;
      score_q    <= score_d;
      sat_q      <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ostat_q  <= ostat_d;
    obad_q   <= obad_d;
    oscore_q <= oscore_d;
    osat_q   <= osat_d;
  end

  assign status_o.stack_empty = empty;
  assign status_o.line_bad    = corrupt_q || exceeded_q;
  assign line_status_o        = ostat_q;
  assign offending_char_o     = obad_q;
  assign completion_score_o   = oscore_q;
  assign score_saturated_o    = osat_q;

endmodule

// ===== rtl/bracket_match_completion_score_top.sv =====
`timescale 1ns / 1ps

// Bracket completion scorer. Characters of a line arrive one per request on
// the slave stream, with tlast on the last character, and are taken back to
// back while no drain is under way. The last character is followed by a drain
// of the open-bracket stack, one entry per cycle from a single read port at the
// top pointer, before the next line's first character is taken. Corrupted and
// overflowed lines skip the drain. The result waits in an output register, and
// the next line's characters are taken while it waits; a second end of line is
// still accepted and its stack drained, but its result is then held back until
// the first result has been taken.
module bracket_match_completion_score_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [7:0]                 s_axis_tdata_i,   // [7:0] character
  input  logic                       s_axis_tlast_i,   // end_of_line
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [1:0] line_status, [9:2] offending_char, [72:10] completion_score,
  // [73] score_saturated, [79:74] zero
  output logic [bmcs_pkg::OUT_W-1:0] m_axis_tdata_o
);

  bmcs_pkg::dp_cmd_t    cmd;
  bmcs_pkg::dp_status_t status;

  logic [1:0]                   line_status;
  logic [bmcs_pkg::CHAR_W-1:0]  offending_char;
  logic [bmcs_pkg::SCORE_W-1:0] completion_score;
  logic                         score_saturated;

  bmcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_eol_i    (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .cmd_o       (cmd)
  );

  bmcs_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .char_i             (s_axis_tdata_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .line_status_o      (line_status),
    .offending_char_o   (offending_char),
    .completion_score_o (completion_score),
    .score_saturated_o  (score_saturated)
  );

  assign m_axis_tdata_o = {6'b000000, score_saturated, completion_score,
                           offending_char, line_status};

`ifndef NO_ASSERTIONS
  // An end of line holds off further characters while the stack drains.
  a_eol_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("character accepted right after end of line");

  // A line that failed carries no score.
  a_bad_no_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (line_status != bmcs_pkg::STATUS_OK)
      |-> (completion_score == '0) && !score_saturated)
    else $error("score reported on a corrupted or overflowed line");

  // Only corrupted lines name an offending character.
  a_bad_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (line_status != bmcs_pkg::STATUS_CORRUPT)
      |-> offending_char == '0)
    else $error("offending character on a line that is not corrupted");

  // The controller never pops and loads a result in the same cycle.
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.pop_en, cmd.load_out, cmd.char_en}) <= 1)
    else $error("conflicting datapath commands");
`endif

endmodule
